FILE: hdl/packed_bit_field_store_unit_defines.svh
// Assertion macros for the packed bit field store unit.
// Included by the top level; depends on nothing else.
`ifndef PACKED_BIT_FIELD_STORE_UNIT_DEFINES_SVH
`define PACKED_BIT_FIELD_STORE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pbfs_pkg.sv
// Shared types, constants and helper functions of the packed bit field store.
// Used by every module of the block but pbfs_ram; depends on nothing.
package pbfs_pkg;

  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned OFF_W           = 6;
  localparam int unsigned STORE_WORDS_DEF = 1024;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned FW_W    = 7;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned NXT_W   = 17;
  localparam int unsigned TB_W    = 17;
  localparam int unsigned START_W = POS_W + FW_W;
  localparam int unsigned BLK_W   = START_W - OFF_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_WIDTH = 2'd1;

  localparam logic [TB_W-1:0] TOTAL_BITS_RST   = 17'h10000;
  localparam logic [FW_W-1:0] RECORD_WIDTH_RST = 7'd0;
  localparam logic [FW_W-1:0] MAX_FIELD_W      = 7'd64;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic             cmd;
    logic             err;
    logic             noop;
    logic             straddle;
    logic [BLK_W-1:0] blk;
    logic [OFF_W-1:0] off;
    logic [FW_W-1:0]  weff;
    logic [VAL_W-1:0] val;
    logic [NXT_W-1:0] nxt;
  } pbfs_job_t;

  function automatic logic [WORD_BITS-1:0] low_ones(input logic [FW_W-1:0] w);
    logic [WORD_BITS-1:0] r;
    if (w >= MAX_FIELD_W) begin
      r = '1;
    end else begin
      r = (WORD_BITS'(1) << w) - WORD_BITS'(1);
    end
    return r;
  endfunction

endpackage

FILE: hdl/pbfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module pbfs_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/pbfs_front.sv
// Front end: configuration registers, item acceptance, start bit computation
// and classification of each access into a job. Depends on pbfs_pkg.
module pbfs_front #(
  parameter int unsigned STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [pbfs_pkg::POS_W-1:0]      position_i,
  input  logic [pbfs_pkg::FW_W-1:0]       field_width_i,
  input  logic [pbfs_pkg::VAL_W-1:0]      write_value_i,
  input  logic                            clearing_i,
  output logic                            push_o,
  output pbfs_pkg::pbfs_job_t             job_o,
  input  logic                            q_full_i
);
  import pbfs_pkg::*;

  localparam logic [START_W-1:0] CAP = START_W'(STORE_WORDS * WORD_BITS);

  logic [TB_W-1:0]    total_bits_q;
  logic [FW_W-1:0]    record_width_q;
  logic               stage_valid_q, stage_valid_d;
  logic               cmd_q;
  logic [POS_W-1:0]   pos_q;
  logic [FW_W-1:0]    fw_q;
  logic [VAL_W-1:0]   val_q;
  logic [START_W-1:0] start_q, start_d;
  logic               accept;

  logic               rec;
  logic [FW_W-1:0]    w;
  logic [TB_W-1:0]    limit;
  logic [START_W:0]   end_w;
  logic               w_big, start_ge, end_gt, val_wide, err;
  logic [FW_W-1:0]    weff;
  logic [OFF_W-1:0]   off;
  logic [NXT_W-1:0]   nxt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bits_q   <= TOTAL_BITS_RST;
      record_width_q <= RECORD_WIDTH_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TOTAL_BITS) begin
        total_bits_q <= cfg_data_i[TB_W-1:0];
      end
      if (cfg_index_i == REG_RECORD_WIDTH) begin
        record_width_q <= cfg_data_i[FW_W-1:0];
      end
    end
  end

  assign busy   = clearing_i || (stage_valid_q && q_full_i);
  assign accept = start && !busy;
  assign push_o = stage_valid_q && !q_full_i;
  assign rec    = record_width_q != '0;

  always_comb begin
    if (rec) begin
      start_d = START_W'(position_i) * START_W'(record_width_q);
    end else begin
      start_d = START_W'(position_i);
    end
    stage_valid_d = accept || (stage_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      pos_q   <= position_i;
      fw_q    <= field_width_i;
      val_q   <= write_value_i;
      start_q <= start_d;
    end
  end

  always_comb begin
    w        = rec ? record_width_q : fw_q;
    limit    = ((START_W'(total_bits_q)) < CAP) ? total_bits_q : CAP[TB_W-1:0];
    end_w    = (START_W + 1)'(start_q) + (START_W + 1)'(w);
    w_big    = w > MAX_FIELD_W;
    start_ge = start_q >= START_W'(limit);
    end_gt   = end_w > (START_W + 1)'(limit);
    val_wide = (val_q & ~low_ones(w)) != '0;
    off      = start_q[OFF_W-1:0];
    nxt      = rec ? (NXT_W'(pos_q) + NXT_W'(1)) : end_w[NXT_W-1:0];
    weff     = w;
    if (cmd_q == CMD_READ) begin
      err = (w != '0) && (w_big || start_ge);
      if (!err && end_gt && (w != '0)) begin
        weff = FW_W'(START_W'(limit) - start_q);
      end
    end else begin
      err = w_big || end_gt || val_wide;
    end

    job_o.cmd      = cmd_q;
    job_o.err      = err;
    job_o.noop     = err || (weff == '0);
    job_o.straddle = ((OFF_W + 2)'(off) + (OFF_W + 2)'(weff)) > (OFF_W + 2)'(WORD_BITS);
    job_o.blk      = start_q[START_W-1:OFF_W];
    job_o.off      = off;
    job_o.weff     = weff;
    job_o.val      = val_q;
    job_o.nxt      = ((cmd_q == CMD_WRITE) && !err) ? nxt : '0;
  end

endmodule

FILE: hdl/pbfs_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on pbfs_pkg for the job type and queue sizing.
module pbfs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pbfs_pkg::pbfs_job_t job_i,
  output logic                full_o,
  input  logic                pop_i,
  output pbfs_pkg::pbfs_job_t head_o,
  output logic                empty_o
);
  import pbfs_pkg::*;

  pbfs_job_t          entries_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == Q_CNT_W'(Q_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: hdl/pbfs_back.sv
// Back end: clearing pass after reset, then one job at a time as a read or a
// read-modify-write of one or two words or none. Depends on pbfs_pkg, pbfs_ram.
module pbfs_back #(
  parameter int unsigned STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pbfs_pkg::pbfs_job_t        head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       clearing_o,
  output logic                       result_valid_o,
  output logic [pbfs_pkg::VAL_W-1:0] read_data_o,
  output logic [pbfs_pkg::NXT_W-1:0] next_position_o,
  output logic                       error_o
);
  import pbfs_pkg::*;

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);
  localparam int unsigned DW = 2 * WORD_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD0   = 3'd2;
  localparam logic [2:0] ST_RD1   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_WR1   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  pbfs_job_t            job_q;
  logic [WORD_BITS-1:0] w0_q, w1_q;
  logic [WORD_BITS-1:0] rdata;

  logic                 we;
  logic [AW-1:0]        waddr, raddr, blk0, blk1;
  logic [WORD_BITS-1:0] wdata;
  logic [DW-1:0]        pair, mask2, val2, merged, shifted;
  logic [WORD_BITS-1:0] rd_field;

  logic                 res_valid_d;
  logic [VAL_W-1:0]     res_data_d;
  logic [NXT_W-1:0]     res_nxt_d;
  logic                 res_err_d;

  pbfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign clearing_o = state_q == ST_CLEAR;
  assign blk0       = job_q.blk[AW-1:0];
  assign blk1       = blk0 + AW'(1);

  always_comb begin
    pair     = {w1_q, w0_q};
    mask2    = DW'(low_ones(job_q.weff)) << job_q.off;
    val2     = DW'(job_q.val) << job_q.off;
    merged   = (pair & ~mask2) | (val2 & mask2);
    shifted  = pair >> job_q.off;
    rd_field = shifted[WORD_BITS-1:0] & low_ones(job_q.weff);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = blk0;
    wdata       = merged[WORD_BITS-1:0];
    raddr       = blk0;
    res_valid_d = 1'b0;
    res_data_d  = '0;
    res_nxt_d   = job_q.nxt;
    res_err_d   = job_q.err;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = head_i.blk[AW-1:0];
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.noop) begin
            res_valid_d = 1'b1;
            res_nxt_d   = head_i.nxt;
            res_err_d   = head_i.err;
          end else begin
            state_d = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        raddr   = blk1;
        state_d = job_q.straddle ? ST_RD1 : ST_DONE;
      end
      ST_RD1: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (job_q.cmd == CMD_READ) begin
          res_valid_d = 1'b1;
          res_data_d  = rd_field;
          state_d     = ST_IDLE;
        end else begin
          we = 1'b1;
          if (job_q.straddle) begin
            state_d = ST_WR1;
          end else begin
            res_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      ST_WR1: begin
        we          = 1'b1;
        waddr       = blk1;
        wdata       = merged[DW-1:WORD_BITS];
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      result_valid_o <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
    if (state_q == ST_RD0) begin
      w0_q <= rdata;
    end
    if (state_q == ST_RD1) begin
      w1_q <= rdata;
    end
    if (res_valid_d) begin
      read_data_o     <= res_data_d;
      next_position_o <= res_nxt_d;
      error_o         <= res_err_d;
    end
  end

endmodule

FILE: hdl/packed_bit_field_store_unit.sv
// Top level of the packed bit field store: front end, job queue and back end.
// Depends on pbfs_pkg, pbfs_front, pbfs_queue, pbfs_back and the defines header.
//
// After reset the unit clears its STORE_WORDS-word store one word per cycle
// (STORE_WORDS is 1024 by default) and holds busy high meanwhile;
// configuration writes are taken at any time. An access is taken when start
// is high and busy is low, and its result appears for one cycle with
// result_valid_o high, which the receiver must take since it cannot stall.
// The front end takes an item every cycle outside the clearing pass while
// the two-entry job queue has room; sustained throughput is set by the
// back-end sequencer, one job at a time, around the single store RAM:
// a refused or zero-width access is answered from ST_IDLE; others pass
// ST_RD0, ST_RD1 if straddling, ST_DONE, and ST_WR1 if a straddling write.
`include "packed_bit_field_store_unit_defines.svh"

module packed_bit_field_store_unit #(
  parameter int unsigned STORE_WORDS = pbfs_pkg::STORE_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pbfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [pbfs_pkg::POS_W-1:0]      position_i,
  input  logic [pbfs_pkg::FW_W-1:0]       field_width_i,
  input  logic [pbfs_pkg::VAL_W-1:0]      write_value_i,
  output logic                            result_valid_o,
  output logic [pbfs_pkg::VAL_W-1:0]      read_data_o,
  output logic [pbfs_pkg::NXT_W-1:0]      next_position_o,
  output logic                            error_o
);
  import pbfs_pkg::*;

  logic      clearing;
  logic      q_push, q_full, q_pop, q_empty;
  pbfs_job_t q_job, q_head;

  pbfs_front #(
    .STORE_WORDS(STORE_WORDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .field_width_i(field_width_i),
    .write_value_i(write_value_i),
    .clearing_i   (clearing),
    .push_o       (q_push),
    .job_o        (q_job),
    .q_full_i     (q_full)
  );

  pbfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head),
    .empty_o(q_empty)
  );

  pbfs_back #(
    .STORE_WORDS(STORE_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .empty_i        (q_empty),
    .pop_o          (q_pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .read_data_o    (read_data_o),
    .next_position_o(next_position_o),
    .error_o        (error_o)
  );

  `PBFS_ASSERT_NOW(a_clear_busy, clk_i, rst_ni, clearing, busy, "busy low during clearing pass")
  `PBFS_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, q_pop, !q_empty, "job popped from empty queue")
  `PBFS_ASSERT_NOW(a_err_zero, clk_i, rst_ni, result_valid_o && error_o, (read_data_o == '0) && (next_position_o == '0), "refused access carries data")
  `PBFS_ASSERT_NEXT(a_noop_result, clk_i, rst_ni, q_pop && q_head.noop, result_valid_o, "trivial job gave no result")

endmodule
